// ===== hw/rtl/sdc_pkg.sv =====
// ----------------------------------------------------------------------------
// sdc_pkg: shared types and functions for the double sha-256 nonce checker
// round constants, sha-256 helper functions and the round cell payload type
// ----------------------------------------------------------------------------
`default_nettype none
package sdc_pkg;

  localparam int unsigned ROUNDS = 64;
  // input accept to result strobe: two chains, two digest stages, one compare stage
  localparam int unsigned LATENCY = 2 * ROUNDS + 3;
  localparam logic [23:0] MANT_MASK = 24'hFFFFFF;
  localparam logic [31:0] PAD_WORD = 32'h80000000;
  localparam logic [31:0] LEN_HEADER = 32'd640;
  localparam logic [31:0] LEN_DIGEST = 32'd256;
  localparam logic [7:0] EXP_MIN = 8'd1;
  localparam logic [7:0] EXP_MAX = 8'd32;

  // register indexes on the configuration port
  localparam logic [2:0] REG_MID0 = 3'd0;
  localparam logic [2:0] REG_MID1 = 3'd1;
  localparam logic [2:0] REG_MID2 = 3'd2;
  localparam logic [2:0] REG_MID3 = 3'd3;
  localparam logic [2:0] REG_MERKLE = 3'd4;
  localparam logic [2:0] REG_TIME = 3'd5;
  localparam logic [2:0] REG_BITS = 3'd6;

  localparam logic [31:0] KROUND [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0][31:0] KINIT = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  typedef logic [7:0][31:0] state_t;
  typedef logic [15:0][31:0] block_t;

  // payload handed from one round cell to the next
  typedef struct packed {
    state_t      st;
    block_t      w;
    logic [31:0] nonce;
  } sdc_cell_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] swap32(input logic [31:0] x);
    swap32 = {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sha256d_nonce_target_check.sv =====
// ----------------------------------------------------------------------------
// sha256d_nonce_target_check: double sha-256 header hash and target check
// finishes an 80-byte header from a midstate and a nonce, hashes it twice
// and flags a hash below the target decoded from the compact bits
// ----------------------------------------------------------------------------
// one nonce beat is taken every clock cycle (busy is tied low); each result
// leaves on out_valid in order, one result per nonce, after passing two chains
// of 64 round cells (one round and one schedule step per cell per cycle), two
// digest add stages and one target compare stage. results cannot be held off
// by the receiver: sample them in the cycle out_valid is high. write the
// registers over apb (byte address 8*index) only when no nonce is in flight.
`default_nettype none
module sha256d_nonce_target_check (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // nonce command
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_nonce,
  // results
  output logic             out_valid,
  output logic [31:0]      out_tried_nonce,
  output logic             out_meets_target,
  output logic [63:0]      out_hash_word_0,
  output logic [63:0]      out_hash_word_1,
  output logic [63:0]      out_hash_word_2,
  output logic [63:0]      out_hash_word_3,
  // apb configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  // configuration registers
  logic [63:0] cfg_mid_r [4];
  logic [31:0] cfg_merkle_r, cfg_time_r, cfg_bits_r;
  logic [2:0]  cfg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign cfg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < 4; j++) begin
        cfg_mid_r[j] <= '0;
      end
      cfg_merkle_r <= '0;
      cfg_time_r   <= '0;
      cfg_bits_r   <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        sdc_pkg::REG_MID0:   cfg_mid_r[0] <= pwdata;
        sdc_pkg::REG_MID1:   cfg_mid_r[1] <= pwdata;
        sdc_pkg::REG_MID2:   cfg_mid_r[2] <= pwdata;
        sdc_pkg::REG_MID3:   cfg_mid_r[3] <= pwdata;
        sdc_pkg::REG_MERKLE: cfg_merkle_r <= pwdata[31:0];
        sdc_pkg::REG_TIME:   cfg_time_r   <= pwdata[31:0];
        sdc_pkg::REG_BITS:   cfg_bits_r   <= pwdata[31:0];
        default: ; // unused slot, write dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      sdc_pkg::REG_MID0:   prdata = cfg_mid_r[0];
      sdc_pkg::REG_MID1:   prdata = cfg_mid_r[1];
      sdc_pkg::REG_MID2:   prdata = cfg_mid_r[2];
      sdc_pkg::REG_MID3:   prdata = cfg_mid_r[3];
      sdc_pkg::REG_MERKLE: prdata = {32'd0, cfg_merkle_r};
      sdc_pkg::REG_TIME:   prdata = {32'd0, cfg_time_r};
      sdc_pkg::REG_BITS:   prdata = {32'd0, cfg_bits_r};
      default:             prdata = '0;
    endcase
  end

  // first hash: midstate plus second header block
  sdc_pkg::state_t mid_state, dig1, dig2;
  sdc_pkg::block_t blk1, blk2;
  logic            v1, v2;
  logic [31:0]     n1, n2;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      mid_state[2 * j]     = cfg_mid_r[j][63:32];
      mid_state[2 * j + 1] = cfg_mid_r[j][31:0];
    end
    blk1     = '0;
    blk1[0]  = cfg_merkle_r;
    blk1[1]  = sdc_pkg::swap32(cfg_time_r);
    blk1[2]  = sdc_pkg::swap32(cfg_bits_r);
    blk1[3]  = sdc_pkg::swap32(in_nonce);
    blk1[4]  = sdc_pkg::PAD_WORD;
    blk1[15] = sdc_pkg::LEN_HEADER;
  end

  sdc_compress u_hash1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_nonce  (in_nonce),
    .in_init   (mid_state),
    .in_block  (blk1),
    .out_valid (v1),
    .out_nonce (n1),
    .out_digest(dig1)
  );

  // second hash over the 32-byte digest
  always_comb begin
    blk2 = '0;
    for (int j = 0; j < 8; j++) begin
      blk2[j] = dig1[j];
    end
    blk2[8]  = sdc_pkg::PAD_WORD;
    blk2[15] = sdc_pkg::LEN_DIGEST;
  end

  sdc_compress u_hash2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v1),
    .in_nonce  (n1),
    .in_init   (sdc_pkg::KINIT),
    .in_block  (blk2),
    .out_valid (v2),
    .out_nonce (n2),
    .out_digest(dig2)
  );

  // hash as little-endian number and decoded target
  logic [255:0] hash_val, target;
  logic [279:0] tgt_wide;
  logic [7:0]   expo;
  logic         meets_nxt;

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      hash_val[32 * j +: 32] = sdc_pkg::swap32(dig2[j]);
    end
    expo     = cfg_bits_r[31:24];
    tgt_wide = {256'd0, cfg_bits_r[23:0] & sdc_pkg::MANT_MASK} << {expo[5:0], 3'b000};
    // exponent out of range gives a zero target, never met
    if (expo inside {[sdc_pkg::EXP_MIN:sdc_pkg::EXP_MAX]}) begin
      target = tgt_wide[279:24];
    end else begin
      target = '0;
    end
    meets_nxt = hash_val < target;
  end

  logic         out_valid_r;
  logic [31:0]  nonce_r;
  logic         meets_r;
  logic [255:0] hash_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v2;
    end
  end

  always_ff @(posedge clk) begin
    nonce_r <= n2;
    meets_r <= meets_nxt;
    hash_r  <= hash_val;
  end

  assign out_valid        = out_valid_r;
  assign out_tried_nonce  = nonce_r;
  assign out_meets_target = meets_r;
  assign out_hash_word_0  = hash_r[63:0];
  assign out_hash_word_1  = hash_r[127:64];
  assign out_hash_word_2  = hash_r[191:128];
  assign out_hash_word_3  = hash_r[255:192];

endmodule
`default_nettype wire

// ===== hw/rtl/sdc_round.sv =====
// ----------------------------------------------------------------------------
// sdc_round: one sha-256 round cell
// one compression round plus one message schedule step, registered
// ----------------------------------------------------------------------------
`default_nettype none
module sdc_round #(
  parameter int unsigned ROUND = 0
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire sdc_pkg::sdc_cell_t in_cell,
  output logic                   out_valid,
  output sdc_pkg::sdc_cell_t     out_cell
);

  logic               valid_r;
  sdc_pkg::sdc_cell_t cell_r, cell_nxt;
  logic [31:0]        t1, t2, ch, maj;

  always_comb begin
    ch  = (in_cell.st[4] & in_cell.st[5]) ^ (~in_cell.st[4] & in_cell.st[6]);
    maj = (in_cell.st[0] & in_cell.st[1]) ^ (in_cell.st[0] & in_cell.st[2])
        ^ (in_cell.st[1] & in_cell.st[2]);
    t1  = in_cell.st[7] + sdc_pkg::bsig1(in_cell.st[4]) + ch
        + sdc_pkg::KROUND[ROUND] + in_cell.w[0];
    t2  = sdc_pkg::bsig0(in_cell.st[0]) + maj;
    cell_nxt.nonce = in_cell.nonce;
    cell_nxt.st[0] = t1 + t2;
    cell_nxt.st[1] = in_cell.st[0];
    cell_nxt.st[2] = in_cell.st[1];
    cell_nxt.st[3] = in_cell.st[2];
    cell_nxt.st[4] = in_cell.st[3] + t1;
    cell_nxt.st[5] = in_cell.st[4];
    cell_nxt.st[6] = in_cell.st[5];
    cell_nxt.st[7] = in_cell.st[6];
    // slide the schedule window by one word
    for (int j = 0; j < 15; j++) begin
      cell_nxt.w[j] = in_cell.w[j + 1];
    end
    cell_nxt.w[15] = in_cell.w[0] + sdc_pkg::ssig0(in_cell.w[1]) + in_cell.w[9]
                   + sdc_pkg::ssig1(in_cell.w[14]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign out_valid = valid_r;
  assign out_cell  = cell_r;

endmodule
`default_nettype wire

// ===== hw/rtl/sdc_compress.sv =====
// ----------------------------------------------------------------------------
// sdc_compress: full sha-256 compression as a chain of round cells
// 64 round cells followed by the registered chaining-value add
// ----------------------------------------------------------------------------
`default_nettype none
module sdc_compress (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic [31:0]     in_nonce,
  input  wire sdc_pkg::state_t in_init,
  input  wire sdc_pkg::block_t in_block,
  output logic                 out_valid,
  output logic [31:0]          out_nonce,
  output sdc_pkg::state_t      out_digest
);

  localparam int unsigned ROUNDS = sdc_pkg::ROUNDS;

  sdc_pkg::sdc_cell_t chain [ROUNDS + 1];
  logic               vld [ROUNDS + 1];
  logic               valid_r;
  logic [31:0]        nonce_r;
  sdc_pkg::state_t    digest_r, digest_nxt;

  assign vld[0]         = in_valid;
  assign chain[0].st    = in_init;
  assign chain[0].w     = in_block;
  assign chain[0].nonce = in_nonce;

  for (genvar i = 0; i < ROUNDS; i++) begin : g_cell
    sdc_round #(.ROUND(i)) u_round (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (vld[i]),
      .in_cell  (chain[i]),
      .out_valid(vld[i + 1]),
      .out_cell (chain[i + 1])
    );
  end

  // chaining value must be held steady by the user while items are in flight; this block does not enforce it
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      digest_nxt[j] = in_init[j] + chain[ROUNDS].st[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= vld[ROUNDS];
    end
  end

  always_ff @(posedge clk) begin
    nonce_r  <= chain[ROUNDS].nonce;
    digest_r <= digest_nxt;
  end

  assign out_valid  = valid_r;
  assign out_nonce  = nonce_r;
  assign out_digest = digest_r;

endmodule
`default_nettype wire

// ===== hw/rtl/sdc_checker.sv =====
// ----------------------------------------------------------------------------
// sdc_checker: port-level checks for the nonce checker
// result strobes and nonces line up with start beats at the fixed latency
// ----------------------------------------------------------------------------
`default_nettype none
module sdc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [31:0] in_nonce,
  input wire logic        out_valid,
  input wire logic [31:0] out_tried_nonce
);

  localparam int unsigned LAT = sdc_pkg::LATENCY;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy asserted");

  a_result_has_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without matching start beat");

  a_nonce_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tried_nonce == $past(in_nonce, LAT)))
    else $error("result nonce does not match start beat");

endmodule

bind sha256d_nonce_target_check sdc_checker u_sdc_checker (.*);
`default_nettype wire
